@@ rtl/core/gcd_pair_count_mobius_unit_defines.svh @@
// Assertion macros for the gcd pair count unit.
// Used by the divider and the datapath; no other dependencies.
`ifndef GCD_PAIR_COUNT_MOBIUS_UNIT_DEFINES_SVH
`define GCD_PAIR_COUNT_MOBIUS_UNIT_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define GPCM_ASSERT(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);
`define GPCM_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) ante |=> cons) else $error(msg);
`else
`define GPCM_ASSERT(lbl, prop, msg)
`define GPCM_ASSERT_NEXT(lbl, ante, cons, msg)
`endif
`endif

@@ rtl/core/gpcm_pkg.sv @@
// Shared types and constants for the gcd pair count unit.
// No dependencies.
`timescale 1ns / 1ps
package gpcm_pkg;
	localparam int VAL_W  = 16;
	localparam int CNT_W  = 32;
	localparam int MERT_W = 12;

	typedef struct packed {
		logic clear_step;
		logic sv_init;
		logic sv_check;
		logic sv_next;
		logic sv_puse;
		logic take_item;
		logic pre1_start;
		logic cap_pre1;
		logic pre2_start;
		logic cap_pre2;
		logic q_init;
		logic q_next;
		logic div1_start;
		logic cap_div1;
		logic div2_start;
		logic cap_div2;
		logic rd_prev;
		logic cap_last;
		logic cap_prev;
		logic mul_step;
		logic acc_step;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic clear_last;
		logic j_end;
		logic q_stop;
		logic p_hit;
		logic item_empty;
		logic div_done;
		logic n_zero;
		logic step_last;
		logic q_last;
		logic out_free;
	} sts_t;

	typedef enum logic [20:0] {
		ST_CLEAR   = 21'h000001,
		ST_SV_RD   = 21'h000002,
		ST_SV_CHK  = 21'h000004,
		ST_SV_PRD  = 21'h000008,
		ST_SV_PUSE = 21'h000010,
		ST_IDLE    = 21'h000020,
		ST_PRE1    = 21'h000040,
		ST_PRE1W   = 21'h000080,
		ST_PRE2    = 21'h000100,
		ST_PRE2W   = 21'h000200,
		ST_QINIT   = 21'h000400,
		ST_DIV1    = 21'h000800,
		ST_DIV1W   = 21'h001000,
		ST_DIV2    = 21'h002000,
		ST_DIV2W   = 21'h004000,
		ST_RDA     = 21'h008000,
		ST_RDB     = 21'h010000,
		ST_RDC     = 21'h020000,
		ST_MUL     = 21'h040000,
		ST_ACC     = 21'h080000,
		ST_OUT     = 21'h100000
	} state_t;
endpackage

@@ rtl/core/gpcm_div.sv @@
// Iterative 16-bit unsigned divider, two quotient bits per cycle.
// Depends on gpcm_pkg and the unit's assertion macros.
`timescale 1ns / 1ps
`include "gcd_pair_count_mobius_unit_defines.svh"
module gpcm_div
	import gpcm_pkg::*;
(
	input  logic             clk,
	input  logic             arst_n,
	input  logic             start,
	input  logic [VAL_W-1:0] dividend,
	input  logic [VAL_W-1:0] divisor,
	output logic             done,
	output logic [VAL_W-1:0] quotient
);
	logic [VAL_W-1:0] rem_q, quo_q, dvs_q;
	logic [2:0]       cnt_q;
	logic             busy_q, done_q;
	logic [2*VAL_W-1:0] one_step, two_step;

	function automatic logic [2*VAL_W-1:0] div_step(input logic [2*VAL_W-1:0] rq,
		input logic [VAL_W-1:0] dv);
		logic [VAL_W:0] r;
		logic [VAL_W:0] s;
		r = {rq[2*VAL_W-1:VAL_W], rq[VAL_W-1]};
		s = r - {1'b0, dv};
		if (!s[VAL_W]) begin
			div_step = {s[VAL_W-1:0], rq[VAL_W-2:0], 1'b1};
		end else begin
			div_step = {r[VAL_W-1:0], rq[VAL_W-2:0], 1'b0};
		end
	endfunction

	assign one_step = div_step({rem_q, quo_q}, dvs_q);
	assign two_step = div_step(one_step, dvs_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 3'd1;
				if (cnt_q == 3'd7) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rem_q <= '0;
			quo_q <= dividend;
			dvs_q <= divisor;
		end else if (busy_q) begin
			rem_q <= two_step[2*VAL_W-1:VAL_W];
			quo_q <= two_step[VAL_W-1:0];
		end
	end

	assign done     = done_q;
	assign quotient = quo_q;

	`GPCM_ASSERT(a_no_restart, start |-> !busy_q, "divider started while busy")
	`GPCM_ASSERT(a_done_after_busy, done_q |-> $past(busy_q), "done without a running division")
	`GPCM_ASSERT_NEXT(a_done_pulse, done_q, !done_q, "done held longer than one cycle")
endmodule

@@ rtl/core/gpcm_datapath.sv @@
// Datapath: sieve tables, quotient walk, dividers, accumulator, output register.
// Depends on gpcm_pkg, gpcm_div and the unit's assertion macros.
`timescale 1ns / 1ps
`include "gcd_pair_count_mobius_unit_defines.svh"
module gpcm_datapath
	import gpcm_pkg::*;
#(
	parameter int TABLE_SIZE = 65536
) (
	input  logic              clk,
	input  logic              arst_n,
	input  cmd_t              cmd,
	output sts_t              sts,
	input  logic [79:0]       s_tdata,
	input  logic              m_tready,
	output logic              m_tvalid,
	output logic [CNT_W-1:0]  m_tdata
);
	localparam int AW   = $clog2(TABLE_SIZE);
	localparam int PCAP = TABLE_SIZE / 2 + 8;
	localparam int PAW  = $clog2(PCAP);
	localparam int PCW  = $clog2(PCAP + 1);
	localparam logic [2*AW-1:0] TS_W = (2*AW)'(TABLE_SIZE);

	logic [AW-1:0]           lpf_mem   [TABLE_SIZE];
	logic signed [1:0]       mu_mem    [TABLE_SIZE];
	logic signed [MERT_W-1:0] mert_mem [TABLE_SIZE];
	logic [AW-1:0]           prime_mem [PCAP];

	logic [AW-1:0]            lpf_rd_q, prime_rd_q;
	logic signed [1:0]        mu_rd_q;
	logic signed [MERT_W-1:0] mert_rd_q;

	logic [AW-1:0]            idx_q, lpf_i_q;
	logic signed [1:0]        mu_i_q;
	logic signed [MERT_W-1:0] macc_q;
	logic [PCW-1:0]           pt_q, j_q;

	logic [VAL_W-1:0] xl_q, xh_q, yl_q, yh_q, k_q;
	logic [VAL_W-1:0] xhq_q, xlq_q, yhq_q, ylq_q;
	logic [1:0]       qsel_q;
	logic [VAL_W-1:0] n_q, m_q, d_q, t1_q, t2_q, last_q;
	logic [CNT_W-1:0] prod_q, term_q, acc_q, count_q;
	logic signed [MERT_W-1:0] ml_q, md_q;
	logic             out_valid_q;

	logic                     is_one, is_prime;
	logic signed [1:0]        mu_cur;
	logic [AW-1:0]            lpf_cur;
	logic signed [MERT_W-1:0] macc_nx;
	logic [2*AW-1:0]          q_full;
	logic                     lpf_we, mu_we, mert_we;
	logic [AW-1:0]            lpf_wa, mert_wa, mert_ra;
	logic [AW-1:0]            lpf_wd;
	logic signed [1:0]        mu_wd;
	logic signed [MERT_W-1:0] mert_wd;
	logic [VAL_W-1:0]         n_sel, m_sel, n_min, m_max;
	logic                     div_start, done_a, done_b;
	logic [VAL_W-1:0]         dvd_a, dvs_a, dvd_b, dvs_b, quo_a, quo_b;
	logic [VAL_W-1:0]         xl_in, yl_in;
	logic signed [MERT_W:0]   diff;
	logic [CNT_W-1:0]         diff_ext;
	logic [2*CNT_W-1:0]       term_full;
	logic [2*VAL_W-1:0]       prod_full;

	function automatic logic [AW-1:0] clamp_idx(input logic [VAL_W-1:0] v);
		if (32'(v) >= 32'(TABLE_SIZE - 1)) begin
			clamp_idx = AW'(TABLE_SIZE - 1);
		end else begin
			clamp_idx = AW'(v);
		end
	endfunction

	// sieve
	assign is_one   = idx_q == AW'(1);
	assign is_prime = !is_one && (lpf_rd_q == '0);
	assign mu_cur   = is_one ? 2'sd1 : (is_prime ? -2'sd1 : mu_rd_q);
	assign lpf_cur  = is_prime ? idx_q : lpf_rd_q;
	assign macc_nx  = macc_q + {{(MERT_W-2){mu_cur[1]}}, mu_cur};
	assign q_full   = idx_q * prime_rd_q;

	always_comb begin
		lpf_we  = cmd.clear_step || cmd.sv_puse;
		mu_we   = lpf_we;
		lpf_wa  = cmd.sv_puse ? q_full[AW-1:0] : idx_q;
		lpf_wd  = cmd.sv_puse ? prime_rd_q : '0;
		mu_wd   = (cmd.sv_puse && !(prime_rd_q == lpf_i_q)) ? -mu_i_q : 2'sd0;
		mert_we = cmd.clear_step || cmd.sv_check;
		mert_wa = idx_q;
		mert_wd = cmd.sv_check ? macc_nx : '0;
		mert_ra = cmd.rd_prev ? clamp_idx(d_q - 16'd1) : clamp_idx(last_q);
	end

	always_ff @(posedge clk) begin
		if (lpf_we) begin
			lpf_mem[lpf_wa] <= lpf_wd;
		end
		lpf_rd_q <= lpf_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (mu_we) begin
			mu_mem[lpf_wa] <= mu_wd;
		end
		mu_rd_q <= mu_mem[idx_q];
	end

	always_ff @(posedge clk) begin
		if (mert_we) begin
			mert_mem[mert_wa] <= mert_wd;
		end
		mert_rd_q <= mert_mem[mert_ra];
	end

	always_ff @(posedge clk) begin
		if (cmd.sv_check && is_prime) begin
			prime_mem[pt_q[PAW-1:0]] <= idx_q;
		end
		prime_rd_q <= prime_mem[j_q[PAW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q  <= '0;
			pt_q   <= '0;
			j_q    <= '0;
			macc_q <= '0;
		end else begin
			if (cmd.sv_init) begin
				idx_q  <= AW'(1);
				pt_q   <= '0;
				macc_q <= '0;
			end else if (cmd.clear_step || cmd.sv_next) begin
				idx_q <= idx_q + AW'(1);
			end
			if (cmd.sv_check) begin
				macc_q <= macc_nx;
				j_q    <= '0;
				if (is_prime) begin
					pt_q <= pt_q + PCW'(1);
				end
			end
			if (cmd.sv_puse) begin
				j_q <= j_q + PCW'(1);
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.sv_check) begin
			mu_i_q  <= mu_cur;
			lpf_i_q <= lpf_cur;
		end
	end

	// item and quotient walk
	assign xl_in = (s_tdata[15:0] == '0) ? 16'd1 : s_tdata[15:0];
	assign yl_in = (s_tdata[47:32] == '0) ? 16'd1 : s_tdata[47:32];
	assign n_sel = qsel_q[0] ? xlq_q : xhq_q;
	assign m_sel = qsel_q[1] ? ylq_q : yhq_q;
	assign n_min = (n_sel < m_sel) ? n_sel : m_sel;
	assign m_max = (n_sel < m_sel) ? m_sel : n_sel;

	always_comb begin
		if (cmd.pre1_start) begin
			dvd_a = xh_q;          dvs_a = k_q;
			dvd_b = yh_q;          dvs_b = k_q;
		end else if (cmd.pre2_start) begin
			dvd_a = xl_q - 16'd1;  dvs_a = k_q;
			dvd_b = yl_q - 16'd1;  dvs_b = k_q;
		end else if (cmd.div1_start) begin
			dvd_a = n_q;           dvs_a = d_q;
			dvd_b = m_q;           dvs_b = d_q;
		end else begin
			dvd_a = n_q;           dvs_a = t1_q;
			dvd_b = m_q;           dvs_b = t2_q;
		end
	end
	assign div_start = cmd.pre1_start || cmd.pre2_start || cmd.div1_start || cmd.div2_start;

	gpcm_div u_div_a (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_a),
		.divisor  (dvs_a),
		.done     (done_a),
		.quotient (quo_a)
	);

	gpcm_div u_div_b (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (dvd_b),
		.divisor  (dvs_b),
		.done     (done_b),
		.quotient (quo_b)
	);

	assign diff      = {ml_q[MERT_W-1], ml_q} - {md_q[MERT_W-1], md_q};
	assign diff_ext  = {{(CNT_W-MERT_W-1){diff[MERT_W]}}, diff};
	assign term_full = diff_ext * prod_q;
	assign prod_full = t1_q * t2_q;

	always_ff @(posedge clk) begin
		if (cmd.take_item) begin
			xl_q <= xl_in;
			xh_q <= s_tdata[31:16];
			yl_q <= yl_in;
			yh_q <= s_tdata[63:48];
			k_q  <= s_tdata[79:64];
		end
		if (cmd.cap_pre1) begin
			xhq_q <= quo_a;
			yhq_q <= quo_b;
		end
		if (cmd.cap_pre2) begin
			xlq_q <= quo_a;
			ylq_q <= quo_b;
		end
		if (cmd.q_init) begin
			n_q <= n_min;
			m_q <= m_max;
			d_q <= 16'd1;
		end
		if (cmd.cap_div1) begin
			t1_q <= quo_a;
			t2_q <= quo_b;
		end
		if (cmd.cap_div2) begin
			last_q <= (quo_a < quo_b) ? quo_a : quo_b;
			prod_q <= prod_full;
		end
		if (cmd.cap_last) begin
			ml_q <= mert_rd_q;
		end
		if (cmd.cap_prev) begin
			md_q <= mert_rd_q;
		end
		if (cmd.mul_step) begin
			term_q <= term_full[CNT_W-1:0];
		end
		if (cmd.acc_step) begin
			d_q <= last_q + 16'd1;
		end
		if (cmd.out_load) begin
			count_q <= acc_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			qsel_q      <= '0;
			acc_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.take_item) begin
				qsel_q <= '0;
				acc_q  <= '0;
			end else begin
				if (cmd.q_next) begin
					qsel_q <= qsel_q + 2'd1;
				end
				if (cmd.acc_step) begin
					acc_q <= (qsel_q[0] ^ qsel_q[1]) ? acc_q - term_q : acc_q + term_q;
				end
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_comb begin
		sts.clear_last = idx_q == AW'(TABLE_SIZE - 1);
		sts.j_end      = j_q >= pt_q;
		sts.q_stop     = q_full >= TS_W;
		sts.p_hit      = prime_rd_q == lpf_i_q;
		sts.item_empty = (k_q == '0) || (xl_q > xh_q) || (yl_q > yh_q);
		sts.div_done   = done_a;
		sts.n_zero     = n_min == '0;
		sts.step_last  = last_q == n_q;
		sts.q_last     = qsel_q == 2'd3;
		sts.out_free   = !out_valid_q || m_tready;
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = count_q;

	`GPCM_ASSERT(a_div_done_pair, done_a == done_b, "dividers out of step")
	`GPCM_ASSERT(a_block_end, cmd.cap_div2 |-> (quo_a >= d_q), "block end below its start")
	`GPCM_ASSERT(a_step_range, cmd.acc_step |-> (last_q >= d_q && last_q <= n_q),
		"block outside query range")
endmodule

@@ rtl/core/gpcm_ctrl.sv @@
// Controller state machine: clearing pass, sieve sequencing, per-item query walk.
// Depends on gpcm_pkg.
`timescale 1ns / 1ps
module gpcm_ctrl
	import gpcm_pkg::*;
(
	input  logic clk,
	input  logic arst_n,
	input  logic s_tvalid,
	output logic s_tready,
	input  sts_t sts,
	output cmd_t cmd
);
	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	assign s_tready = state_q == ST_IDLE;

	always_comb begin
		cmd     = '0;
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.clear_step = 1'b1;
				if (sts.clear_last) begin
					cmd.sv_init = 1'b1;
					state_d     = ST_SV_RD;
				end
			end
			ST_SV_RD: begin
				state_d = ST_SV_CHK;
			end
			ST_SV_CHK: begin
				cmd.sv_check = 1'b1;
				state_d      = ST_SV_PRD;
			end
			ST_SV_PRD: begin
				if (!sts.j_end) begin
					state_d = ST_SV_PUSE;
				end else if (sts.clear_last) begin
					state_d = ST_IDLE;
				end else begin
					cmd.sv_next = 1'b1;
					state_d     = ST_SV_RD;
				end
			end
			ST_SV_PUSE: begin
				if (!sts.q_stop) begin
					cmd.sv_puse = 1'b1;
				end
				if (!sts.q_stop && !sts.p_hit) begin
					state_d = ST_SV_PRD;
				end else if (sts.clear_last) begin
					state_d = ST_IDLE;
				end else begin
					cmd.sv_next = 1'b1;
					state_d     = ST_SV_RD;
				end
			end
			ST_IDLE: begin
				if (s_tvalid) begin
					cmd.take_item = 1'b1;
					state_d       = ST_PRE1;
				end
			end
			ST_PRE1: begin
				if (sts.item_empty) begin
					state_d = ST_OUT;
				end else begin
					cmd.pre1_start = 1'b1;
					state_d        = ST_PRE1W;
				end
			end
			ST_PRE1W: begin
				if (sts.div_done) begin
					cmd.cap_pre1 = 1'b1;
					state_d      = ST_PRE2;
				end
			end
			ST_PRE2: begin
				cmd.pre2_start = 1'b1;
				state_d        = ST_PRE2W;
			end
			ST_PRE2W: begin
				if (sts.div_done) begin
					cmd.cap_pre2 = 1'b1;
					state_d      = ST_QINIT;
				end
			end
			ST_QINIT: begin
				cmd.q_init = 1'b1;
				if (!sts.n_zero) begin
					state_d = ST_DIV1;
				end else begin
					cmd.q_next = 1'b1;
					state_d    = sts.q_last ? ST_OUT : ST_QINIT;
				end
			end
			ST_DIV1: begin
				cmd.div1_start = 1'b1;
				state_d        = ST_DIV1W;
			end
			ST_DIV1W: begin
				if (sts.div_done) begin
					cmd.cap_div1 = 1'b1;
					state_d      = ST_DIV2;
				end
			end
			ST_DIV2: begin
				cmd.div2_start = 1'b1;
				state_d        = ST_DIV2W;
			end
			ST_DIV2W: begin
				if (sts.div_done) begin
					cmd.cap_div2 = 1'b1;
					state_d      = ST_RDA;
				end
			end
			ST_RDA: begin
				state_d = ST_RDB;
			end
			ST_RDB: begin
				cmd.rd_prev  = 1'b1;
				cmd.cap_last = 1'b1;
				state_d      = ST_RDC;
			end
			ST_RDC: begin
				cmd.cap_prev = 1'b1;
				state_d      = ST_MUL;
			end
			ST_MUL: begin
				cmd.mul_step = 1'b1;
				state_d      = ST_ACC;
			end
			ST_ACC: begin
				cmd.acc_step = 1'b1;
				if (!sts.step_last) begin
					state_d = ST_DIV1;
				end else begin
					cmd.q_next = 1'b1;
					state_d    = sts.q_last ? ST_OUT : ST_QINIT;
				end
			end
			ST_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_CLEAR;
			end
		endcase
	end
endmodule

@@ rtl/core/gcd_pair_count_mobius_unit.sv @@
// Gcd pair counter: for a rectangle of pairs and a divisor k, counts pairs whose gcd is k.
// Input stream s_*: one transfer per query. Output stream m_*: one transfer per query.
// After reset a clearing pass over every table entry runs, then a linear sieve fills the
// Mertens table. s_tready stays low until the table is complete. Each query runs four
// inclusion-exclusion sums. Every divisor block takes two rounds of the pair of dividers
// plus two table reads and the multiply-accumulate. A sum over N <= M takes at most about
// 2*sqrt(N)+2*sqrt(M) blocks; an empty rectangle or a zero divisor skips the sums.
// One query is in work at a time; the next is accepted once the previous result has
// been moved into the output register, so one result may wait while the next query
// runs. If m_tready stays low, the finished result of the next query waits in the
// accumulator until the output register frees.
// Depends on gpcm_pkg, gpcm_ctrl, gpcm_datapath.
`timescale 1ns / 1ps
module gcd_pair_count_mobius_unit
	import gpcm_pkg::*;
#(
	parameter int TABLE_SIZE = 65536
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_tvalid,
	output logic        s_tready,
	// x_low, x_high, y_low, y_high, gcd_target
	input  logic [79:0] s_tdata,
	output logic        m_tvalid,
	input  logic        m_tready,
	// pair_count
	output logic [31:0] m_tdata
);
	cmd_t cmd;
	sts_t sts;

	gpcm_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	gpcm_datapath #(
		.TABLE_SIZE (TABLE_SIZE)
	) u_datapath (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.s_tdata  (s_tdata),
		.m_tready (m_tready),
		.m_tvalid (m_tvalid),
		.m_tdata  (m_tdata)
	);
endmodule

@@ tb/sv/tb.sv @@
// Self-checking bench for gcd_pair_count_mobius_unit: gcd-k pair counts over rectangles.
// Predicts unlisted counts from its Mertens table and Mobius block sums; needs gpcm_pkg.
`timescale 1ns / 1ps
module tb;
	import gpcm_pkg::*;

	localparam int TBL = 65536;
	localparam longint CYCLE_LIMIT = 6000000;

	typedef struct {
		logic [15:0] xl, xh, yl, yh, k;
		bit          known;
		logic [31:0] want;
	} query_t;

	logic        clk = 0;
	logic        arst_n = 0;
	logic        s_tvalid = 0;
	logic        s_tready;
	logic [79:0] s_tdata = '0;
	logic        m_tvalid;
	logic        m_tready = 0;
	logic [31:0] m_tdata;

	int          mert[TBL];
	logic [31:0] count_due[$];
	int          errors = 0;
	int          snd_idle = 0, rcv_idle = 0;
	logic        hold_go = 0;
	bit          hold_done = 0;
	int          hold_cnt = 0;
	longint      cycles = 0;

	gcd_pair_count_mobius_unit DUT (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	always begin
		#6 clk = 1;
		#6 clk = 0;
	end

	function automatic void build_mertens();
		bit comp[];
		int primes[$];
		int q;
		comp = new[TBL];
		foreach (mert[i]) mert[i] = 0;
		mert[1] = 1;
		for (int i = 2; i < TBL; i++) begin
			if (!comp[i]) begin
				primes.push_back(i);
				mert[i] = -1;
			end
			for (int j = 0; j < primes.size(); j++) begin
				q = i * primes[j];
				if (q >= TBL) break;
				comp[q] = 1;
				if (i % primes[j] == 0) begin
					mert[q] = 0;
					break;
				end
				mert[q] = -mert[i];
			end
			mert[i] += mert[i-1];
		end
	endfunction

	function automatic longint coprime_pairs(longint n, longint m);
		longint t, d, lst, t1, t2, a, b, sum;
		sum = 0;
		if (n > m) begin
			t = n; n = m; m = t;
		end
		d = 1;
		while (d <= n) begin
			t1 = n / d;
			t2 = m / d;
			a = n / t1;
			b = m / t2;
			lst = a < b ? a : b;
			sum += longint'(mert[lst] - mert[d-1]) * t1 * t2;
			d = lst + 1;
		end
		return sum;
	endfunction

	function automatic logic [31:0] gcd_pair_count(query_t c);
		longint xl, xh, yl, yh, k, tot;
		xl = c.xl == 0 ? 1 : c.xl;
		yl = c.yl == 0 ? 1 : c.yl;
		xh = c.xh; yh = c.yh; k = c.k;
		if (k == 0 || xl > xh || yl > yh) return '0;
		tot = coprime_pairs(xh / k, yh / k) - coprime_pairs((xl - 1) / k, yh / k)
			- coprime_pairs(xh / k, (yl - 1) / k) + coprime_pairs((xl - 1) / k, (yl - 1) / k);
		return tot[31:0];
	endfunction

	task automatic send_query(query_t c);
		while ($urandom_range(0, 99) < snd_idle) begin
			s_tvalid <= 0;
			@(posedge clk);
		end
		s_tvalid <= 1;
		s_tdata <= {c.k, c.yh, c.yl, c.xh, c.xl};
		@(posedge clk);
		while (!s_tready) @(posedge clk);
		count_due.push_back(c.known ? c.want : gcd_pair_count(c));
	endtask

	function automatic query_t rand_query(int mode);
		query_t c;
		c.known = 0;
		c.want = '0;
		case (mode)
			0: begin
				c.xl = 16'($urandom); c.xh = 16'($urandom);
				c.yl = 16'($urandom); c.yh = 16'($urandom);
				c.k = ($urandom_range(0, 1) == 0) ? 16'd0 : 16'($urandom);
			end
			7, 8: begin
				c.xl = 16'($urandom_range(0, 300)); c.xh = 16'($urandom_range(c.xl, 300));
				c.yl = 16'($urandom_range(0, 300)); c.yh = 16'($urandom_range(c.yl, 300));
				c.k = 16'($urandom_range(1, 20));
			end
			9: begin
				c.xl = 16'($urandom_range(0, 4000)); c.xh = 16'($urandom_range(c.xl, 4000));
				c.yl = 16'($urandom_range(0, 4000)); c.yh = 16'($urandom_range(c.yl, 4000));
				c.k = 16'($urandom_range(1, 4));
			end
			default: begin
				c.xl = 16'($urandom); c.xh = 16'($urandom_range(c.xl, 65535));
				c.yl = 16'($urandom); c.yh = 16'($urandom_range(c.yl, 65535));
				c.k = 16'($urandom_range(256, 65535));
			end
		endcase
		return c;
	endfunction

	// extremes, zero divisor, zero low bound, empty rectangles
	query_t directed[17] = '{
		'{1, 1, 1, 1, 1, 1, 32'd1},
		'{0, 10, 0, 10, 0, 1, 32'd0},
		'{0, 1, 0, 1, 1, 1, 32'd1},
		'{5, 4, 1, 10, 1, 1, 32'd0},
		'{1, 10, 9, 8, 1, 1, 32'd0},
		'{65535, 0, 65535, 0, 65535, 1, 32'd0},
		'{65535, 65535, 65535, 65535, 65535, 1, 32'd1},
		'{1, 65535, 1, 65535, 65535, 1, 32'd1},
		'{1, 65535, 1, 1, 1, 1, 32'd65535},
		'{12, 12, 18, 18, 6, 1, 32'd1},
		'{12, 12, 18, 18, 3, 1, 32'd0},
		'{1, 65535, 1, 65535, 1, 0, 32'd0},
		'{65535, 65535, 1, 65535, 1, 0, 32'd0},
		'{0, 65535, 0, 65535, 2, 0, 32'd0},
		'{1, 100, 1, 100, 3, 0, 32'd0},
		'{40000, 65535, 1, 30, 7, 0, 32'd0},
		'{2, 2, 4, 4, 2, 0, 32'd0}
	};

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			if (count_due.size() == 0) begin
				$display("%0t: unexpected pair_count %0d", $time, m_tdata);
				errors++;
			end else begin
				if (m_tdata !== count_due[0]) begin
					$display("%0t: pair_count expected %0d actual %0d",
						$time, count_due[0], m_tdata);
					errors++;
				end
				void'(count_due.pop_front());
			end
		end
		if (!arst_n) begin
			m_tready <= 0;
		end else if (hold_go && !hold_done) begin
			m_tready <= 0;
			hold_cnt++;
			if (hold_cnt >= 3000) hold_done = 1;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= rcv_idle);
		end
	end

	initial begin
		build_mertens();
		repeat (6) @(posedge clk);
		arst_n <= 1;
		snd_idle = 19;
		rcv_idle = 52;
		foreach (directed[i]) send_query(directed[i]);
		for (int ph = 0; ph < 3; ph++) begin
			if (ph == 1) begin
				snd_idle = 52;
				rcv_idle = 19;
			end else if (ph == 2) begin
				snd_idle = 0;
				rcv_idle = 0;
				hold_go <= 1;
				// cheap transfers pile up behind the stalled output
				for (int i = 0; i < 8; i++) send_query(rand_query(0));
			end
			for (int i = 0; i < 25; i++) send_query(rand_query($urandom_range(0, 9)));
		end
		s_tvalid <= 0;
		while (count_due.size() != 0) @(posedge clk);
		repeat (200) @(posedge clk);
		if (errors == 0) begin
			$display("Testbench completed without errors");
		end else begin
			$display("Testbench completed WITH ERRORS");
		end
		$finish;
	end
endmodule
